// ===== sv/dnns_pkg.sv =====
// Shared types and constants for the directional nearest-neighbor search.
package dnns_pkg;

  localparam int AGENT_COUNT = 256;
  localparam int IDX_W       = $clog2(AGENT_COUNT);
  localparam int POS_W       = 20;
  localparam int AIM_W       = 3;
  localparam int DIST_W      = 14;

  localparam logic [20:0]       NARROW_LANE  = 21'd102;
  localparam logic [20:0]       WIDE_LANE    = 21'd307;
  localparam logic [DIST_W-1:0] DEFAULT_DIST = 14'd10240;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [AIM_W-1:0] AIM_PARKED = 3'd0;
  localparam logic [AIM_W-1:0] AIM_DOWN   = 3'd1;
  localparam logic [AIM_W-1:0] AIM_AISLE  = 3'd2;
  localparam logic [AIM_W-1:0] AIM_UP     = 3'd3;
  localparam logic [AIM_W-1:0] AIM_IN     = 3'd4;

  typedef struct packed {
    logic [AIM_W-1:0]        aim;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } agent_t;

  typedef struct packed {
    logic              take;
    logic [DIST_W-1:0] span;
  } eval_res_t;

endpackage

// ===== sv/dnns_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dnns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dnns_eval.sv =====
// Separation unit: judges one table entry against the querying agent.
module dnns_eval (
  input  dnns_pkg::agent_t                q_ent,
  input  logic [dnns_pkg::IDX_W-1:0]      q_idx,
  input  dnns_pkg::agent_t                o_ent,
  input  logic [dnns_pkg::IDX_W-1:0]      o_idx,
  input  logic [dnns_pkg::DIST_W-1:0]     best_d,
  output dnns_pkg::eval_res_t             res
);

  logic signed [20:0] dx;
  logic signed [20:0] dy;
  logic [20:0]        adx;
  logic [20:0]        ady;
  logic signed [20:0] sep;
  logic               lane_ok;
  logic               sep_pos;
  logic               sep_lt;

  always_comb begin
    dx  = $signed({o_ent.x[19], o_ent.x}) - $signed({q_ent.x[19], q_ent.x});
    dy  = $signed({o_ent.y[19], o_ent.y}) - $signed({q_ent.y[19], q_ent.y});
    adx = dx[20] ? 21'(-dx) : 21'(dx);
    ady = dy[20] ? 21'(-dy) : 21'(dy);

    lane_ok = 1'b0;
    sep     = '0;
    case (q_ent.aim)
      dnns_pkg::AIM_DOWN: begin
        lane_ok = (adx <= dnns_pkg::NARROW_LANE);
        sep     = -dy;
      end
      dnns_pkg::AIM_AISLE: begin
        lane_ok = (adx <= dnns_pkg::WIDE_LANE);
        sep     = -dy;
      end
      dnns_pkg::AIM_UP: begin
        lane_ok = (adx <= dnns_pkg::NARROW_LANE);
        sep     = dy;
      end
      dnns_pkg::AIM_IN: begin
        lane_ok = (ady <= dnns_pkg::NARROW_LANE);
        sep     = -dx;
      end
      default: begin
        lane_ok = 1'b0;
        sep     = '0;
      end
    endcase

    sep_pos = !sep[20] && (sep != '0);
    sep_lt  = (sep[19:0] < 20'(best_d));

    res.take = lane_ok && sep_pos && sep_lt && (o_ent.aim != dnns_pkg::AIM_PARKED)
               && (o_idx != q_idx);
    res.span = sep[dnns_pkg::DIST_W-1:0];
  end

endmodule

// ===== sv/directional_nearest_neighbor_search.sv =====
// Top level: agent table, scan sequencer and result register.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+-----
//   in      | in_valid/in_ready, mode index pos aim     | in
//   out     | out_valid/out_ready, found index x y span | out
//   cfg     | cfg_wr_en, cfg_wr_data (exit_x)           | in
//
// A write item is accepted in IDLE and the block is ready again right away.
// A query item runs one load step, AGENT_COUNT - 1 scan steps, one drain step
// for the RAM read latency and one result step before the next accept; the table
// RAM delivers one entry per cycle.
// Reset clears the valid bit of every entry at once; no clearing pass.
// A result waiting on out_ready holds the next query at its final step only.
module directional_nearest_neighbor_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_mode,
  input  logic [7:0]                          in_agent_index,
  input  logic signed [19:0]                  in_pos_x,
  input  logic signed [19:0]                  in_pos_y,
  input  logic [2:0]                          in_aim,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_found,
  output logic [7:0]                          out_nearest_index,
  output logic signed [19:0]                  out_nearest_x,
  output logic signed [19:0]                  out_nearest_y,
  output logic [13:0]                         out_span,
  input  logic                                cfg_wr_en,
  input  logic signed [19:0]                  cfg_wr_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_QLOAD = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [dnns_pkg::IDX_W-1:0] LAST_IDX =
    dnns_pkg::IDX_W'(dnns_pkg::AGENT_COUNT - 1);

  logic [2:0] state_r, state_nxt;
  logic [dnns_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic [dnns_pkg::IDX_W-1:0] q_idx_r, q_idx_nxt;
  dnns_pkg::agent_t q_ent_r, q_ent_nxt;

  logic [dnns_pkg::AGENT_COUNT-1:0] valid_r;
  logic rd_valid_r;
  logic cmp_vld_r;
  logic [dnns_pkg::IDX_W-1:0] cmp_idx_r;

  logic signed [19:0] exit_x_r;

  logic found_r, found_nxt;
  logic [dnns_pkg::IDX_W-1:0] best_i_r, best_i_nxt;
  logic signed [19:0] best_x_r, best_x_nxt;
  logic signed [19:0] best_y_r, best_y_nxt;
  logic [dnns_pkg::DIST_W-1:0] best_d_r, best_d_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_found_r;
  logic [7:0] out_index_r;
  logic signed [19:0] out_x_r;
  logic signed [19:0] out_y_r;
  logic [13:0] out_dist_r;

  logic in_acc;
  logic wr_en;
  logic [dnns_pkg::IDX_W-1:0] rd_addr;
  logic [dnns_pkg::IDX_W-1:0] in_idx;
  dnns_pkg::agent_t wr_ent;
  dnns_pkg::agent_t rd_data;
  dnns_pkg::agent_t o_ent;
  dnns_pkg::eval_res_t ev;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign in_idx   = in_agent_index[dnns_pkg::IDX_W-1:0];
  assign wr_en    = in_acc && (in_mode == dnns_pkg::MODE_WRITE);
  assign wr_ent   = '{aim: in_aim, y: in_pos_y, x: in_pos_x};
  assign rd_addr  = (state_r == S_IDLE) ? in_idx : cnt_r;
  // an entry never written since reset reads as parked at the origin
  assign o_ent    = rd_valid_r ? rd_data : '0;

  dnns_ram #(
    .WIDTH($bits(dnns_pkg::agent_t)),
    .DEPTH(dnns_pkg::AGENT_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (wr_en),
    .waddr(in_idx),
    .wdata(wr_ent),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  dnns_eval u_eval (
    .q_ent (q_ent_r),
    .q_idx (q_idx_r),
    .o_ent (o_ent),
    .o_idx (cmp_idx_r),
    .best_d(best_d_r),
    .res   (ev)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    q_idx_nxt     = q_idx_r;
    q_ent_nxt     = q_ent_r;
    found_nxt     = found_r;
    best_i_nxt    = best_i_r;
    best_x_nxt    = best_x_r;
    best_y_nxt    = best_y_r;
    best_d_nxt    = best_d_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmp_vld_r && ev.take) begin
      found_nxt  = 1'b1;
      best_i_nxt = cmp_idx_r;
      best_x_nxt = o_ent.x;
      best_y_nxt = o_ent.y;
      best_d_nxt = ev.span;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_mode == dnns_pkg::MODE_QUERY)) begin
          q_idx_nxt = in_idx;
          cnt_nxt   = '0;
          state_nxt = S_QLOAD;
        end
      end
      S_QLOAD: begin
        q_ent_nxt  = o_ent;
        found_nxt  = 1'b0;
        best_i_nxt = '0;
        best_x_nxt = exit_x_r;
        best_y_nxt = '0;
        best_d_nxt = dnns_pkg::DEFAULT_DIST;
        cnt_nxt    = cnt_r + 1'b1;
        state_nxt  = S_SCAN;
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      rd_valid_r  <= 1'b0;
      cmp_vld_r   <= 1'b0;
      exit_x_r    <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_valid_r  <= valid_r[rd_addr];
      cmp_vld_r   <= (state_r == S_QLOAD) || (state_r == S_SCAN);
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        valid_r[in_idx] <= 1'b1;
      end
      if (cfg_wr_en) begin
        exit_x_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_idx_r   <= q_idx_nxt;
    q_ent_r   <= q_ent_nxt;
    cmp_idx_r <= rd_addr;
    found_r   <= found_nxt;
    best_i_r  <= best_i_nxt;
    best_x_r  <= best_x_nxt;
    best_y_r  <= best_y_nxt;
    best_d_r  <= best_d_nxt;
    if ((state_r == S_DONE) && (!out_valid_r || out_ready)) begin
      out_found_r <= found_r;
      out_index_r <= 8'(best_i_r);
      out_x_r     <= best_x_r;
      out_y_r     <= best_y_r;
      out_dist_r  <= best_d_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_nearest_index = out_index_r;
  assign out_nearest_x     = out_x_r;
  assign out_nearest_y     = out_y_r;
  assign out_span          = out_dist_r;

endmodule

// ===== sv/dnns_checker.sv =====
// Port-level checks for the nearest-neighbor search, bound to the top level.
module dnns_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               in_mode,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_found,
  input logic [7:0]         out_nearest_index,
  input logic signed [19:0] out_nearest_x,
  input logic signed [19:0] out_nearest_y,
  input logic [13:0]        out_span
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found)
      && $stable(out_nearest_index) && $stable(out_nearest_x)
      && $stable(out_nearest_y) && $stable(out_span))
    else $error("result changed while stalled");

  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_nearest_index == 8'd0
      && out_nearest_y == 20'sd0 && out_span == 14'd10240)
    else $error("not-found result carries wrong fallback");

  a_found_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_span != 14'd0
      && out_span < 14'd10240)
    else $error("found distance out of range");

  // after a query is accepted the block is not ready while it loads and begins its scan
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == dnns_pkg::MODE_QUERY) |=> !in_ready ##1 !in_ready)
    else $error("ready during query scan");

endmodule

bind directional_nearest_neighbor_search dnns_checker u_dnns_checker (.*);
